// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // control characters
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // space on black, attribute in the high byte
    localparam logic [15:0] BLANK_CELL = {8'h00, CHAR_SPACE};

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_INC,
        CUR_DEC,
        CUR_HOME,
        CUR_SCROLL
    } t_cur_cmd;

    typedef struct packed {
        logic is_last;
        logic is_zero;
    } t_cur_stat;

endpackage

// File: hdl/tcw_in_if.sv
`timescale 1ns / 1ps

interface tcw_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  char_code;
    logic [3:0]  fore_color;
    logic [3:0]  back_color;
    logic [10:0] read_index;

    modport source (
        output valid, operation, char_code, fore_color, back_color, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, fore_color, back_color, read_index,
        output ready
    );
endinterface

// File: hdl/tcw_out_if.sv
`timescale 1ns / 1ps

interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_at;

    modport source (
        output valid, cell_char, cell_attr, cursor_at,
        input  ready
    );
    modport sink (
        input  valid, cell_char, cell_attr, cursor_at,
        output ready
    );
endinterface

// File: hdl/tcw_cell_ram.sv
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter  int DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor #(
    parameter  int COLUMNS  = 80,
    parameter  int ROWS     = 25,
    parameter  int TAB_STOP = 8,
    localparam int EXTENT   = COLUMNS * ROWS,
    localparam int CW       = $clog2(EXTENT),
    localparam int COLW     = $clog2(COLUMNS),
    localparam int TW       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_cur_cmd   i_cmd,
    output logic [CW-1:0]       o_cursor,
    output logic [COLW-1:0]     o_col,
    output logic [TW-1:0]       o_tph,
    output tcw_pkg::t_cur_stat  o_stat
);

    import tcw_pkg::*;

    localparam logic [CW-1:0]   LAST    = CW'(EXTENT - 1);
    localparam logic [CW-1:0]   SCR_POS = CW'(EXTENT - COLUMNS);
    localparam logic [COLW-1:0] COL_MAX = COLW'(COLUMNS - 1);
    localparam logic [TW-1:0]   TAB_MAX = TW'(TAB_STOP - 1);
    localparam logic [TW-1:0]   SCR_PH  = TW'((EXTENT - COLUMNS) % TAB_STOP);
    localparam logic [TW:0]     ROW_K   = (TW+1)'(COLUMNS % TAB_STOP);
    localparam logic [TW:0]     ROW_KC  = (TW+1)'(TAB_STOP - (COLUMNS % TAB_STOP));

    // cursor, its column, its tab phase and the tab phase of its row start
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [TW-1:0]   r_tph, n_tph;
    logic [TW-1:0]   r_rs, n_rs;

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_tph    = r_tph;
        n_rs     = r_rs;
        case (i_cmd)
            CUR_INC: begin
                if (r_cursor != LAST) begin
                    n_cursor = r_cursor + 1'b1;
                    n_tph    = (r_tph == TAB_MAX) ? '0 : r_tph + 1'b1;
                    if (r_col == COL_MAX) begin
                        n_col = '0;
                        n_rs  = n_tph;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            CUR_DEC: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - 1'b1;
                    n_tph    = (r_tph == '0) ? TAB_MAX : r_tph - 1'b1;
                    if (r_col == '0) begin
                        n_col = COL_MAX;
                        // previous row start phase: rs - COLUMNS mod TAB_STOP
                        if ({1'b0, r_rs} >= ROW_K) begin
                            n_rs = TW'({1'b0, r_rs} - ROW_K);
                        end else begin
                            n_rs = TW'({1'b0, r_rs} + ROW_KC);
                        end
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
            end
            CUR_HOME: begin
                n_cursor = r_cursor - CW'(r_col);
                n_col    = '0;
                n_tph    = r_rs;
            end
            CUR_SCROLL: begin
                n_cursor = SCR_POS;
                n_col    = '0;
                n_tph    = SCR_PH;
                n_rs     = SCR_PH;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_tph    <= '0;
            r_rs     <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_tph    <= n_tph;
            r_rs     <= n_rs;
        end
    end

    assign o_cursor       = r_cursor;
    assign o_col          = r_col;
    assign o_tph          = r_tph;
    assign o_stat.is_last = (r_cursor == LAST);
    assign o_stat.is_zero = (r_cursor == '0);

endmodule

// File: hdl/text_console_char_writer_core.sv
`timescale 1ns / 1ps

// Text console character writer.
// i_in carries one item per transaction: a put of char_code at the cursor
// (operation 0) or a read of cell read_index (operation 1). o_out returns
// exactly one result per item: the read cell (zero for puts and for reads
// beyond the screen) and the cursor after the item.
// One item at a time: i_in.ready is high only while the sequencer is idle.
// A read passes through S_READ and S_RDOUT into the output register; an
// ordinary character, carriage return or backspace through S_DISPATCH and
// S_DONE; a newline or tab that writes n blanks through S_DISPATCH, S_FILL
// and S_DONE. Ready returns as the result registers. A put with the cursor
// on the last cell first scrolls: the single RAM port pair copies the screen
// up one row, one cell per cycle, and blanks the last row.
// After reset the cell RAM is cleared one cell per cycle before the first
// item is accepted; the cursor resets to zero.
// A result waits in the output register while o_out.ready is low; the next
// item is still accepted, and its result is held back until the slot frees.
module text_console_char_writer_core #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out
);

    import tcw_pkg::*;

    localparam int EXTENT = COLUMNS * ROWS;
    localparam int CW     = $clog2(EXTENT);
    localparam int COLW   = $clog2(COLUMNS);
    localparam int TW     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int MAXN   = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
    localparam int LW     = $clog2(MAXN + 1);

    localparam logic [CW-1:0] LAST     = CW'(EXTENT - 1);
    localparam logic [CW-1:0] COL_ADDR = CW'(COLUMNS);
    localparam logic [CW-1:0] ROW_LAST = CW'(EXTENT - COLUMNS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RDOUT,
        S_DISPATCH,
        S_FILL,
        S_SCR_COPY,
        S_SCR_DRAIN,
        S_SCR_BLANK,
        S_DONE
    } t_state;

    t_state       r_state;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_wa;
    logic          r_cp_v;
    logic          r_ret_fill;
    logic [LW-1:0] r_left;
    logic [7:0]    r_char;
    logic [7:0]    r_attr;
    logic [10:0]   r_idx;
    logic          r_rd_ok;
    logic          r_out_v;
    logic [7:0]    r_out_char;
    logic [7:0]    r_out_attr;
    logic [10:0]   r_out_cur;

    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [CW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    t_cur_cmd        cur_cmd;
    logic [CW-1:0]   w_cursor;
    logic [COLW-1:0] w_col;
    logic [TW-1:0]   w_tph;
    t_cur_stat       w_stat;

    logic in_fire;
    logic out_free;
    logic out_load;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_v || o_out.ready;
    assign out_load = out_free && (r_state == S_RDOUT || r_state == S_DONE);

    tcw_cell_ram #(
        .DEPTH (EXTENT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cur_cmd),
        .o_cursor (w_cursor),
        .o_col    (w_col),
        .o_tph    (w_tph),
        .o_stat   (w_stat)
    );

    // RAM port and cursor command decode
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = w_cursor;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        cur_cmd   = CUR_NONE;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
            end
            S_READ: begin
                ram_re    = r_rd_ok;
                ram_raddr = CW'(r_idx);
            end
            S_DISPATCH: begin
                if (!w_stat.is_last) begin
                    if (r_char == CHAR_CR) begin
                        cur_cmd = CUR_HOME;
                    end else if (r_char == CHAR_BS) begin
                        if (!w_stat.is_zero) begin
                            cur_cmd = CUR_DEC;
                        end
                    end else if (r_char != CHAR_NL && r_char != CHAR_TAB) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_attr, r_char};
                        cur_cmd   = CUR_INC;
                    end
                end
            end
            S_FILL: begin
                if (r_left != '0 && !w_stat.is_last) begin
                    ram_we  = 1'b1;
                    cur_cmd = CUR_INC;
                end
            end
            S_SCR_COPY: begin
                ram_re    = 1'b1;
                ram_we    = r_cp_v;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
            end
            S_SCR_DRAIN: begin
                ram_we    = r_cp_v;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
            end
            S_SCR_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                if (r_addr == LAST) begin
                    cur_cmd = CUR_SCROLL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_cp_v     <= 1'b0;
            r_ret_fill <= 1'b0;
            r_left     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_out_v && o_out.ready && !out_load) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in.operation == OP_READ) begin
                            r_idx   <= i_in.read_index;
                            r_rd_ok <= (int'(i_in.read_index) < EXTENT);
                            r_state <= S_READ;
                        end else begin
                            r_char  <= i_in.char_code;
                            r_attr  <= {i_in.back_color, i_in.fore_color};
                            r_state <= S_DISPATCH;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_RDOUT;
                end
                S_RDOUT: begin
                    if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_char <= r_rd_ok ? ram_rdata[7:0] : 8'h00;
                        r_out_attr <= r_rd_ok ? ram_rdata[15:8] : 8'h00;
                        r_out_cur  <= 11'(w_cursor);
                        r_state    <= S_IDLE;
                    end
                end
                S_DISPATCH: begin
                    if (w_stat.is_last) begin
                        r_addr     <= COL_ADDR;
                        r_cp_v     <= 1'b0;
                        r_ret_fill <= 1'b0;
                        r_state    <= S_SCR_COPY;
                    end else if (r_char == CHAR_NL) begin
                        r_left  <= LW'(COLUMNS) - LW'(w_col);
                        r_state <= S_FILL;
                    end else if (r_char == CHAR_TAB) begin
                        r_left  <= LW'(TAB_STOP) - LW'(w_tph);
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FILL: begin
                    if (r_left == '0) begin
                        r_state <= S_DONE;
                    end else if (w_stat.is_last) begin
                        r_addr     <= COL_ADDR;
                        r_cp_v     <= 1'b0;
                        r_ret_fill <= 1'b1;
                        r_state    <= S_SCR_COPY;
                    end else begin
                        r_left <= r_left - 1'b1;
                    end
                end
                S_SCR_COPY: begin
                    // read cell i now, write it to i - COLUMNS next cycle
                    r_wa   <= r_addr - COL_ADDR;
                    r_cp_v <= 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_SCR_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_SCR_DRAIN: begin
                    r_cp_v  <= 1'b0;
                    r_addr  <= ROW_LAST;
                    r_state <= S_SCR_BLANK;
                end
                S_SCR_BLANK: begin
                    if (r_addr == LAST) begin
                        r_state <= r_ret_fill ? S_FILL : S_DISPATCH;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_char <= 8'h00;
                        r_out_attr <= 8'h00;
                        r_out_cur  <= 11'(w_cursor);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_v;
    assign o_out.cell_char = r_out_char;
    assign o_out.cell_attr = r_out_attr;
    assign o_out.cursor_at = r_out_cur;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input accepted during RAM clear");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cursor <= LAST)
        else $error("cursor beyond last cell");

    a_drain_has_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_DRAIN) |-> r_cp_v)
        else $error("scroll drain without pending copy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting an item");

endmodule

// File: sim/text_console_char_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int TAB   = 8;
    localparam int CELLS = COLS * ROWS;

    typedef struct {
        logic        operation;
        logic [7:0]  char_code;
        logic [3:0]  fore_color;
        logic [3:0]  back_color;
        logic [10:0] read_index;
    } t_console_cmd;

    typedef struct {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [10:0] cursor_at;
    } t_cell_view;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  in_if ();
    tcw_out_if out_if ();

    text_console_char_writer_core #(
        .COLUMNS  (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // screen image and cursor as the block should hold them
    logic [15:0] screen_cells [CELLS];
    int          screen_cursor;

    t_cell_view  cell_view_q [$];
    int          mismatch_count   = 0;
    bit          src_idle_en      = 1'b1;
    bit          sink_idle_en     = 1'b1;
    int          sink_hold_cycles = 0;

    function automatic void screen_clear();
        for (int i = 0; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
        screen_cursor = 0;
    endfunction

    // scroll up one row when the cursor sits on the last cell
    function automatic void screen_scroll_check();
        if (screen_cursor + 1 >= CELLS) begin
            for (int i = COLS; i < CELLS; i++) screen_cells[i - COLS] = screen_cells[i];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
            screen_cursor = CELLS - COLS;
        end
    endfunction

    function automatic void screen_write(logic [7:0] ch, logic [7:0] attr);
        screen_scroll_check();
        screen_cells[screen_cursor] = {attr, ch};
        if (screen_cursor + 1 < CELLS) screen_cursor++;
        else screen_cursor = CELLS - 1;
    endfunction

    function automatic t_cell_view screen_apply(t_console_cmd c);
        t_cell_view v;
        int         n;
        v.cell_char = '0;
        v.cell_attr = '0;
        if (c.operation == OP_READ) begin
            if (int'(c.read_index) < CELLS) begin
                v.cell_char = screen_cells[c.read_index][7:0];
                v.cell_attr = screen_cells[c.read_index][15:8];
            end
        end else begin
            screen_scroll_check();
            case (c.char_code)
                CHAR_NL, CHAR_TAB: begin
                    // column is taken after the scroll check
                    if (c.char_code == CHAR_NL) n = COLS - (screen_cursor % COLS);
                    else n = TAB - (screen_cursor % TAB);
                    repeat (n) screen_write(CHAR_SPACE, 8'h00);
                end
                CHAR_CR: screen_cursor -= screen_cursor % COLS;
                CHAR_BS: if (screen_cursor != 0) screen_cursor--;
                default: screen_write(c.char_code, {c.back_color, c.fore_color});
            endcase
        end
        v.cursor_at = screen_cursor[10:0];
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // must be called at a rising edge; returns at the accepting edge
    task automatic send_item(t_console_cmd c);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= c.operation;
        in_if.char_code  <= c.char_code;
        in_if.fore_color <= c.fore_color;
        in_if.back_color <= c.back_color;
        in_if.read_index <= c.read_index;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        cell_view_q.push_back(screen_apply(c));
    endtask

    task automatic send_put(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
        t_console_cmd c;
        c.operation  = OP_PUT;
        c.char_code  = ch;
        c.fore_color = fg;
        c.back_color = bg;
        c.read_index = 11'($urandom);
        send_item(c);
    endtask

    task automatic send_read(int idx);
        t_console_cmd c;
        c.operation  = OP_READ;
        c.char_code  = 8'($urandom);
        c.fore_color = 4'($urandom);
        c.back_color = 4'($urandom);
        c.read_index = idx[10:0];
        send_item(c);
    endtask

    task automatic send_plain_char();
        send_put(8'($urandom_range(32, 126)), 4'($urandom), 4'($urandom));
    endtask

    // bring the cursor onto the last cell by newlines, then tabs, then plain characters
    task automatic move_to_last_cell();
        while (screen_cursor < CELLS - COLS) send_put(CHAR_NL, 4'($urandom), 4'($urandom));
        while (screen_cursor < CELLS - TAB) send_put(CHAR_TAB, 4'($urandom), 4'($urandom));
        while (screen_cursor < CELLS - 1) send_plain_char();
    endtask

    task automatic send_random_item();
        int pick;
        int lo;
        pick = $urandom_range(0, 99);
        if (pick < 4) send_put(CHAR_NL, 4'($urandom), 4'($urandom));
        else if (pick < 8) send_put(CHAR_TAB, 4'($urandom), 4'($urandom));
        else if (pick < 11) send_put(CHAR_CR, 4'($urandom), 4'($urandom));
        else if (pick < 15) send_put(CHAR_BS, 4'($urandom), 4'($urandom));
        else if (pick < 25) send_put(8'($urandom), 4'($urandom), 4'($urandom));
        else if (pick < 60) send_plain_char();
        else if (pick < 70) send_read($urandom_range(0, 2047));
        else if (pick < 73) send_read($urandom_range(CELLS, 2047));
        else begin
            // look back at recently written cells
            lo = (screen_cursor > 160) ? screen_cursor - 160 : 0;
            send_read($urandom_range(lo, screen_cursor));
        end
    endtask

    task automatic test_special_cases();
        send_put(CHAR_BS, 4'h0, 4'h0);       // backspace at cell zero stays
        send_put(CHAR_CR, 4'hF, 4'hF);
        send_read(0);
        send_put(8'h41, 4'hF, 4'hF);
        send_put(8'h00, 4'h0, 4'h0);
        send_put(8'hFF, 4'h5, 4'hA);
        send_read(0);
        send_read(1);
        send_read(2);
        send_put(CHAR_TAB, 4'h3, 4'hC);
        send_put(CHAR_BS, 4'h0, 4'h0);
        send_put(CHAR_CR, 4'h0, 4'h0);
        send_put(CHAR_NL, 4'hF, 4'hF);
        send_put(8'h07, 4'hA, 4'h5);         // other control bytes print as-is
        send_put(8'h0C, 4'h1, 4'h8);
        send_put(CHAR_NL, 4'h0, 4'h0);
        send_read(81);
        send_read(CELLS - 1);
        send_read(CELLS);
        send_read(2047);
        send_read(1024);
    endtask

    task automatic test_scroll_paths();
        move_to_last_cell();
        send_read(CELLS - 1);
        send_put(CHAR_BS, 4'h0, 4'h0);       // scroll, then step back
        send_put(CHAR_NL, 4'h0, 4'h0);
        while (screen_cursor < CELLS - TAB) send_put(CHAR_TAB, 4'h0, 4'h0);
        send_put(CHAR_TAB, 4'h0, 4'h0);      // tab fill runs into a scroll
        move_to_last_cell();
        send_put(CHAR_CR, 4'h0, 4'h0);       // scroll, then home the row
        move_to_last_cell();
        send_put(CHAR_NL, 4'h0, 4'h0);       // line fill scrolls twice
        move_to_last_cell();
        send_put(CHAR_TAB, 4'h0, 4'h0);
        move_to_last_cell();
        send_put(8'($urandom_range(32, 126)), 4'($urandom), 4'($urandom));
        send_read(CELLS - COLS - 1);
        send_read(CELLS - COLS);
    endtask

    task automatic test_random_traffic(int n);
        repeat (n) send_random_item();
    endtask

    task automatic test_backpressure();
        src_idle_en      = 1'b0;
        sink_hold_cycles = 400;
        repeat (20) send_random_item();
        src_idle_en      = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (2) begin
            repeat (30) send_random_item();
            in_if.valid <= 1'b0;
            while (cell_view_q.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic test_unthrottled(int n);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (n) send_random_item();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int         stall;
        t_cell_view want;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 5) : 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
            if (cell_view_q.size() == 0) begin
                report_mismatch("result with no transaction pending", out_if.cursor_at, -1);
            end else begin
                want = cell_view_q.pop_front();
                if (out_if.cell_char !== want.cell_char)
                    report_mismatch("cell_char", out_if.cell_char, want.cell_char);
                if (out_if.cell_attr !== want.cell_attr)
                    report_mismatch("cell_attr", out_if.cell_attr, want.cell_attr);
                if (out_if.cursor_at !== want.cursor_at)
                    report_mismatch("cursor_at", out_if.cursor_at, want.cursor_at);
            end
        end
    end

    initial begin
        #30_000_000;
        $display("text_console_char_writer_core: mismatch");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.operation  <= OP_PUT;
        in_if.char_code  <= '0;
        in_if.fore_color <= '0;
        in_if.back_color <= '0;
        in_if.read_index <= '0;
        screen_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_scroll_paths();
        test_random_traffic(760);
        test_backpressure();
        test_drain_pause();
        test_unthrottled(60);

        in_if.valid <= 1'b0;
        while (cell_view_q.size() != 0) @(posedge i_clk);
        // wait out a scroll, which touches every cell of the screen
        repeat (CELLS + 200) @(posedge i_clk);
        if (mismatch_count == 0 && cell_view_q.size() == 0) begin
            $display("text_console_char_writer_core: match");
        end else begin
            $display("text_console_char_writer_core: mismatch");
        end
        $finish;
    end

endmodule
